@@ hw/rtl/greedy_box_nms_core_macros.svh @@
// ------------------------------------------------------------------------
// Assertion macros for the greedy box NMS core
// Clocked implication checks, disabled while the active-low reset is low.
// ------------------------------------------------------------------------
`ifndef GREEDY_BOX_NMS_CORE_MACROS_SVH
`define GREEDY_BOX_NMS_CORE_MACROS_SVH

// same-cycle implication
`define GBNMS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define GBNMS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/gbnms_pkg.sv @@
// ------------------------------------------------------------------------
// gbnms_pkg
// Shared constants and helpers for the greedy box NMS core.
// ------------------------------------------------------------------------
package gbnms_pkg;

    localparam int MAX_BOXES_DEF = 64;
    localparam int COORD_W       = 16;
    localparam int BOX_W         = 4 * COORD_W;
    localparam int SCORE_W       = 16;
    localparam int THR_W         = 17;
    localparam logic [THR_W-1:0] THR_RESET = 17'd45875;
    localparam int KEPT_INDEX_W  = 6;
    localparam int KEPT_TOTAL_W  = 7;
    localparam int S_TDATA_W     = 80;
    localparam int M_TDATA_W     = 16;

    // register indexes
    localparam logic REG_IOU_THRESHOLD = 1'b0;

    // overlap length of two inclusive intervals, clamped at zero
    function automatic logic [16:0] overlap_len(
        input logic [COORD_W-1:0] a_lo, input logic [COORD_W-1:0] a_hi,
        input logic [COORD_W-1:0] b_lo, input logic [COORD_W-1:0] b_hi);
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
        logic signed [17:0] d;
        lo = (a_lo > b_lo) ? a_lo : b_lo;
        hi = (a_hi < b_hi) ? a_hi : b_hi;
        d  = $signed({2'b00, hi}) - $signed({2'b00, lo}) + 18'sd1;
        return d[17] ? 17'd0 : d[16:0];
    endfunction

    // signed extent of one box side, max - min + 1
    function automatic logic signed [17:0] extent(
        input logic [COORD_W-1:0] lo, input logic [COORD_W-1:0] hi);
        return $signed({2'b00, hi}) - $signed({2'b00, lo}) + 18'sd1;
    endfunction

endpackage

@@ hw/rtl/greedy_box_nms_core.sv @@
// Loading takes one box per cycle while s_tvalid is high; the set closes on the box with s_tlast.
// Ranking uses one score RAM read port and a pairwise count.
// Suppression works through each pair in turn on the box RAM read port and
// the shared 17x17 multipliers; output skips suppressed entries and holds in OUT_W until m_tready.
// One set is worked at a time; s_tready is low from the closing box until the
// emit pass finishes. Synchronous active-low reset clears control and flags.
// ------------------------------------------------------------------------
// greedy_box_nms_core
// Greedy non-maximum suppression over one set of boxes held in RAM.
// ------------------------------------------------------------------------
module greedy_box_nms_core
    import gbnms_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // APB configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // box input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // x_min, y_min, x_max, y_max, score
    input  logic                 s_tlast,   // last_box
    // kept output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // kept_index, kept_total, zero pad
    output logic                 m_tlast    // last_kept
);

    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);

    typedef enum logic [4:0] {
        ST_LOAD, RK_ISSUE, RK_CAP, RK_RD, RK_CMP, RK_WR,
        SP_I, SP_RI, SP_RB, SP_AREA, SP_J, SP_JR, SP_JB,
        SP_C1, SP_C2, SP_C3, SP_C4, SP_C5, SP_C6,
        OUT_I, OUT_R, OUT_W
    } state_t;

    state_t                     state_reg;
    logic [THR_W-1:0]           thr_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              i_reg;
    logic [CW-1:0]              j_reg;
    logic [CW-1:0]              rank_cnt_reg;
    logic [CW-1:0]              kept_reg;
    logic [CW-1:0]              emit_reg;
    logic [SCORE_W-1:0]         si_reg;
    logic [MAX_BOXES-1:0]       supp_reg;
    logic [BOX_W-1:0]           cur_reg;
    logic [BOX_W-1:0]           oth_reg;
    logic [16:0]                w_reg;
    logic [16:0]                h_reg;
    logic signed [35:0]         cur_area_reg;
    logic signed [35:0]         oth_area_reg;
    logic [33:0]                inter_reg;
    logic signed [37:0]         uni_reg;
    logic [33:0]                plo_reg;
    logic [33:0]                phi_reg;
    logic                       m_valid_reg;
    logic [KEPT_INDEX_W-1:0]    m_index_reg;
    logic [KEPT_TOTAL_W-1:0]    m_total_reg;
    logic                       m_last_reg;

    logic                       box_we;
    logic [BOX_W-1:0]           box_rdata;
    logic [SCORE_W-1:0]         score_rdata;
    logic [IW-1:0]              score_raddr;
    logic                       rank_we;
    logic [IW-1:0]              rank_raddr;
    logic [IW-1:0]              rank_rdata;
    logic                       cfg_wr;
    logic                       in_req;
    logic [50:0]                prod;
    logic [50:0]                lhs;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_IOU_THRESHOLD) ? 32'(thr_reg) : 32'd0;
    assign s_tready = (state_reg == ST_LOAD);
    assign in_req   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_total_reg, m_index_reg};
    assign m_tlast  = m_last_reg;

    // RAM port steering
    assign box_we      = in_req && (count_reg < CW'(MAX_BOXES));
    assign score_raddr = (state_reg == RK_ISSUE) ? i_reg[IW-1:0] : j_reg[IW-1:0];
    assign rank_we     = (state_reg == RK_WR);
    assign rank_raddr  = (state_reg == SP_J) ? j_reg[IW-1:0] : i_reg[IW-1:0];

    // threshold compare operands
    assign prod = {phi_reg, 17'd0} + 51'(plo_reg);
    assign lhs  = {1'b0, inter_reg, 16'd0};

    gbnms_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
        .aclk    (aclk),
        .wr_en   (box_we),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (s_tdata[BOX_W-1:0]),
        .rd_addr (rank_rdata),
        .rd_data (box_rdata)
    );

    gbnms_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_BOXES)) u_score_ram (
        .aclk    (aclk),
        .wr_en   (box_we),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (s_tdata[BOX_W+SCORE_W-1:BOX_W]),
        .rd_addr (score_raddr),
        .rd_data (score_rdata)
    );

    gbnms_ram #(.WIDTH(IW), .DEPTH(MAX_BOXES)) u_rank_ram (
        .aclk    (aclk),
        .wr_en   (rank_we),
        .wr_addr (rank_cnt_reg[IW-1:0]),
        .wr_data (i_reg[IW-1:0]),
        .rd_addr (rank_raddr),
        .rd_data (rank_rdata)
    );

    // sequencer: load, rank, suppress, emit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            thr_reg     <= THR_RESET;
            count_reg   <= '0;
            supp_reg    <= '0;
            m_valid_reg <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
        end else begin
            if (cfg_wr && paddr[2] == REG_IOU_THRESHOLD) begin
                thr_reg <= pwdata[THR_W-1:0];
            end
            unique case (state_reg)
                ST_LOAD: begin
                    if (in_req) begin
                        if (box_we) count_reg <= count_reg + 1'b1;
                        if (s_tlast) begin
                            i_reg     <= '0;
                            state_reg <= RK_ISSUE;
                        end
                    end
                end
                // rank of box i = boxes scoring higher, ties to lower index
                RK_ISSUE: state_reg <= RK_CAP;
                RK_CAP: begin
                    si_reg       <= score_rdata;
                    j_reg        <= '0;
                    rank_cnt_reg <= '0;
                    state_reg    <= RK_RD;
                end
                RK_RD: state_reg <= RK_CMP;
                RK_CMP: begin
                    if (score_rdata > si_reg || (score_rdata == si_reg && j_reg < i_reg)) begin
                        rank_cnt_reg <= rank_cnt_reg + 1'b1;
                    end
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= (j_reg + 1'b1 == count_reg) ? RK_WR : RK_RD;
                end
                RK_WR: begin
                    if (i_reg + 1'b1 == count_reg) begin
                        i_reg     <= '0;
                        supp_reg  <= '0;
                        kept_reg  <= '0;
                        state_reg <= SP_I;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= RK_ISSUE;
                    end
                end
                // walk the ranking
                SP_I: begin
                    if (i_reg == count_reg) begin
                        i_reg     <= '0;
                        emit_reg  <= '0;
                        state_reg <= OUT_I;
                    end else if (supp_reg[i_reg[IW-1:0]]) begin
                        i_reg <= i_reg + 1'b1;
                    end else begin
                        state_reg <= SP_RI;
                    end
                end
                SP_RI: state_reg <= SP_RB;
                SP_RB: begin
                    cur_reg   <= box_rdata;
                    kept_reg  <= kept_reg + 1'b1;
                    j_reg     <= i_reg + 1'b1;
                    state_reg <= SP_AREA;
                end
                SP_AREA: begin
                    cur_area_reg <= extent(cur_reg[15:0], cur_reg[47:32])
                                  * extent(cur_reg[31:16], cur_reg[63:48]);
                    state_reg    <= SP_J;
                end
                SP_J: begin
                    if (j_reg == count_reg) begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= SP_I;
                    end else if (supp_reg[j_reg[IW-1:0]]) begin
                        j_reg <= j_reg + 1'b1;
                    end else begin
                        state_reg <= SP_JR;
                    end
                end
                SP_JR: state_reg <= SP_JB;
                SP_JB: begin
                    oth_reg   <= box_rdata;
                    state_reg <= SP_C1;
                end
                SP_C1: begin
                    w_reg <= overlap_len(cur_reg[15:0], cur_reg[47:32],
                                         oth_reg[15:0], oth_reg[47:32]);
                    h_reg <= overlap_len(cur_reg[31:16], cur_reg[63:48],
                                         oth_reg[31:16], oth_reg[63:48]);
                    oth_area_reg <= extent(oth_reg[15:0], oth_reg[47:32])
                                  * extent(oth_reg[31:16], oth_reg[63:48]);
                    state_reg <= SP_C2;
                end
                SP_C2: begin
                    inter_reg <= w_reg * h_reg;
                    state_reg <= SP_C3;
                end
                SP_C3: begin
                    uni_reg   <= 38'(cur_area_reg) + 38'(oth_area_reg)
                               - $signed({4'b0000, inter_reg});
                    state_reg <= SP_C4;
                end
                SP_C4: begin
                    if (uni_reg <= 38'sd0) begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= SP_J;
                    end else begin
                        plo_reg   <= thr_reg * uni_reg[16:0];
                        state_reg <= SP_C5;
                    end
                end
                SP_C5: begin
                    phi_reg   <= thr_reg * uni_reg[33:17];
                    state_reg <= SP_C6;
                end
                SP_C6: begin
                    if (lhs >= prod) supp_reg[j_reg[IW-1:0]] <= 1'b1;
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= SP_J;
                end
                // emit unsuppressed entries in rank order
                OUT_I: begin
                    if (i_reg == count_reg) begin
                        count_reg <= '0;
                        state_reg <= ST_LOAD;
                    end else if (supp_reg[i_reg[IW-1:0]]) begin
                        i_reg <= i_reg + 1'b1;
                    end else begin
                        state_reg <= OUT_R;
                    end
                end
                OUT_R: begin
                    m_valid_reg <= 1'b1;
                    m_index_reg <= KEPT_INDEX_W'(rank_rdata);
                    m_total_reg <= KEPT_TOTAL_W'(kept_reg);
                    m_last_reg  <= (emit_reg + 1'b1 == kept_reg);
                    state_reg   <= OUT_W;
                end
                OUT_W: begin
                    if (m_tready) begin
                        m_valid_reg <= 1'b0;
                        emit_reg    <= emit_reg + 1'b1;
                        i_reg       <= i_reg + 1'b1;
                        state_reg   <= OUT_I;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

endmodule

@@ hw/rtl/gbnms_ram.sv @@
// ------------------------------------------------------------------------
// gbnms_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ------------------------------------------------------------------------
module gbnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hw/rtl/gbnms_checker.sv @@
// ------------------------------------------------------------------------
// gbnms_checker
// Port-level checks on the greedy box NMS core, bound to the top level.
// ------------------------------------------------------------------------
`include "greedy_box_nms_core_macros.svh"

module gbnms_checker
    import gbnms_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // a stalled result request holds
    `GBNMS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    // no box is taken while results drain
    `GBNMS_ASSERT_NOW(a_no_load_in_emit, aclk, aresetn, m_tvalid, !s_tready)
    // every result reports at least one survivor
    `GBNMS_ASSERT_NOW(a_total_nonzero, aclk, aresetn, m_tvalid, m_tdata[12:6] != 7'd0)
    // after the final result is taken, the output valid drops
    `GBNMS_ASSERT_NEXT(a_reload_after_last, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid)

endmodule

bind greedy_box_nms_core gbnms_checker u_gbnms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
